/* design/cdfec_pkg.sv */
`default_nettype none
package cdfec_pkg;

    localparam int MAX_RUN_FRAMES    = 32;
    localparam int SAMPLES_PER_FRAME = 6;

    localparam int RUN_W     = $clog2(MAX_RUN_FRAMES + 1);
    localparam int TOT_W     = $clog2(MAX_RUN_FRAMES * SAMPLES_PER_FRAME + 1);
    localparam int NUM_W     = TOT_W + 17;
    localparam int MEM_DEPTH = 3 * MAX_RUN_FRAMES;
    localparam int ADDR_W    = $clog2(MEM_DEPTH);
    localparam int FRAME_W   = 192;

    localparam logic [1:0] KIND_GOOD      = 2'd0;
    localparam logic [1:0] KIND_SILENCE   = 2'd1;
    localparam logic [1:0] KIND_CONCEALED = 2'd2;
    localparam logic [1:0] KIND_PASSED    = 2'd3;

    localparam logic [1:0] MODE_SILENCE = 2'd0;
    localparam logic [1:0] MODE_PASS    = 2'd1;
    localparam logic [1:0] MODE_LINEAR  = 2'd2;
    localparam logic [1:0] MODE_PREDICT = 2'd3;

    localparam logic [1:0] CFG_MODE = 2'd0;
    localparam logic [1:0] CFG_PAD  = 2'd1;
    localparam logic [1:0] CFG_THR  = 2'd2;

    localparam logic [15:0] THR_RESET = 16'd1024;

    typedef logic [FRAME_W-1:0] t_frame;
    typedef logic signed [NUM_W-1:0] t_num;

    typedef struct packed {
        logic start;
        t_num num;
    } t_div_req;

    function automatic t_num sx16(input logic [15:0] v);
        sx16 = {{(NUM_W-16){v[15]}}, v};
    endfunction

endpackage
`default_nettype wire

/* design/cdfec_div.sv */
`default_nettype none
module cdfec_div (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    input  cdfec_pkg::t_div_req            i_req,
    input  logic [cdfec_pkg::TOT_W-1:0]    i_den,
    output logic                           o_done,
    output logic [15:0]                    o_quo
);
    import cdfec_pkg::*;

    localparam int CNT_W = $clog2(NUM_W + 1);

    logic               r_busy;
    logic [CNT_W-1:0]   r_cnt;
    logic [TOT_W-1:0]   r_rem;
    logic [NUM_W-1:0]   r_q;
    logic               r_neg;
    logic [TOT_W:0]     trial;
    logic [TOT_W:0]     diff;
    logic               ge;

    assign trial = {r_rem, r_q[NUM_W-1]};
    assign ge    = trial >= {1'b0, i_den};
    assign diff  = trial - {1'b0, i_den};

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_cnt  <= '0;
        end else if (i_req.start) begin
            r_busy <= 1'b1;
            r_cnt  <= CNT_W'(NUM_W);
            r_neg  <= i_req.num[NUM_W-1];
            r_q    <= i_req.num[NUM_W-1] ? NUM_W'(-i_req.num) : NUM_W'(i_req.num);
            r_rem  <= '0;
        end else if (r_busy) begin
            r_rem <= ge ? diff[TOT_W-1:0] : trial[TOT_W-1:0];
            r_q   <= {r_q[NUM_W-2:0], ge};
            r_cnt <= r_cnt - CNT_W'(1);
            if (r_cnt == CNT_W'(1)) begin
                r_busy <= 1'b0;
            end
        end
    end

    assign o_done = !r_busy;
    assign o_quo  = r_neg ? (16'd0 - r_q[15:0]) : r_q[15:0];

endmodule
`default_nettype wire

/* design/cd_audio_frame_error_concealer.sv */
`default_nettype none
// Channel | Direction | Handshake                 | Payload
// cfg     | in        | i_cfg_we                  | i_cfg_idx, i_cfg_data
// in      | in        | i_in_valid / o_in_stall   | i_in_bytes_*, i_frame_corrupt/missing
// out     | out       | o_out_valid / i_out_stall | o_out_bytes_*, o_frame_kind, o_last_of_run
// A frame is taken whenever the block is idle; a corrupt frame in conceal mode is then stored
// as three 64-bit words. Run playback builds each held frame with the bit-serial dividers
// (one per channel, one quotient bit a cycle), which run once per stereo sample.
// A silence flush emits one frame a cycle while the output does not stall; reset is
// synchronous and needs no clearing pass. Output stalls hold the emitting state.
module cd_audio_frame_error_concealer (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_cfg_we,
    input  logic [1:0]  i_cfg_idx,
    input  logic [15:0] i_cfg_data,
    input  logic        i_in_valid,
    output logic        o_in_stall,
    input  logic [63:0] i_in_bytes_low,
    input  logic [63:0] i_in_bytes_mid,
    input  logic [63:0] i_in_bytes_high,
    input  logic        i_frame_corrupt,
    input  logic        i_frame_missing,
    output logic        o_out_valid,
    input  logic        i_out_stall,
    output logic [63:0] o_out_bytes_low,
    output logic [63:0] o_out_bytes_mid,
    output logic [63:0] o_out_bytes_high,
    output logic [1:0]  o_frame_kind,
    output logic        o_last_of_run
);
    import cdfec_pkg::*;

    localparam logic [2:0] ST_IDLE  = 3'd0;
    localparam logic [2:0] ST_FLUSH = 3'd1;
    localparam logic [2:0] ST_STORE = 3'd2;
    localparam logic [2:0] ST_CINIT = 3'd3;
    localparam logic [2:0] ST_CSTART = 3'd4;
    localparam logic [2:0] ST_CWAIT = 3'd5;
    localparam logic [2:0] ST_CEMIT = 3'd6;
    localparam logic [2:0] ST_FINAL = 3'd7;

    logic [1:0]        r_mode;
    logic              r_pad;
    logic [15:0]       r_thr;
    logic              r_seen;
    logic [15:0]       r_prior_l;
    logic [15:0]       r_prior_r;
    logic [RUN_W-1:0]  r_run_len;
    logic [2:0]        r_state;
    t_frame            r_in;
    logic              r_good;
    logic [1:0]        r_fin_kind;
    logic              r_has_fin;
    logic              r_do_store;
    logic [RUN_W-1:0]  r_cnt;
    logic [2:0]        r_x;
    logic [ADDR_W-1:0] r_base;
    logic [TOT_W-1:0]  r_tot;
    t_num              r_dl;
    t_num              r_dr;
    t_num              r_num_l;
    t_num              r_num_r;
    t_frame            r_frame;
    logic [63:0]       r_rd_data;
    logic [63:0]       r_mem [0:MEM_DEPTH-1];
    logic              r_o_valid;
    t_frame            r_o_data;
    logic [1:0]        r_o_kind;
    logic              r_o_last;

    logic              acc;
    logic              good;
    logic              gate;
    logic              out_free;
    logic              last_frame;
    logic              emit;
    t_frame            e_data;
    logic [1:0]        e_kind;
    logic              e_last;
    logic              mem_we;
    logic [ADDR_W-1:0] mem_waddr;
    logic [ADDR_W-1:0] mem_raddr;
    logic [63:0]       mem_wdata;
    t_div_req          req_l;
    t_div_req          req_r;
    logic              done_l;
    logic              done_r;
    logic [15:0]       quo_l;
    logic [15:0]       quo_r;
    logic [31:0]       gsel;
    logic [15:0]       smp_l;
    logic [15:0]       smp_r;
    logic [16:0]       dif_l;
    logic [16:0]       dif_r;
    logic [16:0]       abs_l;
    logic [16:0]       abs_r;
    logic [ADDR_W-1:0] base3;
    logic [TOT_W-1:0]  tot6;
    logic [15:0]       end_l;
    logic [15:0]       end_r;
    logic              do_flush;
    logic              do_store;
    logic              do_conc;
    logic              has_fin;
    logic [1:0]        fin_kind;

    assign acc      = i_in_valid && (r_state == ST_IDLE);
    assign good     = !i_frame_corrupt && !i_frame_missing;
    assign gate     = r_pad || r_seen || good;
    assign out_free = !r_o_valid || !i_out_stall;
    assign last_frame = (r_cnt == r_run_len - RUN_W'(1));
    assign base3    = ADDR_W'({r_run_len, 1'b0}) + ADDR_W'(r_run_len);
    assign tot6     = TOT_W'({r_run_len, 2'b00}) + TOT_W'({r_run_len, 1'b0});
    assign end_l    = good ? i_in_bytes_low[15:0] : 16'd0;
    assign end_r    = good ? i_in_bytes_low[31:16] : 16'd0;

    always_comb begin
        do_flush = (!r_mode[1] && r_run_len != '0) ||
                   (r_mode[1] && i_frame_corrupt && r_run_len == RUN_W'(MAX_RUN_FRAMES));
        do_store = r_mode[1] && i_frame_corrupt;
        do_conc  = r_mode[1] && !i_frame_corrupt && r_run_len != '0;
        if (!r_mode[1]) begin
            has_fin = gate;
            if (good) begin
                fin_kind = KIND_GOOD;
            end else if (i_frame_missing || r_mode == MODE_SILENCE) begin
                fin_kind = KIND_SILENCE;
            end else begin
                fin_kind = KIND_PASSED;
            end
        end else begin
            has_fin  = !i_frame_corrupt && gate;
            fin_kind = good ? KIND_GOOD : KIND_SILENCE;
        end
    end

    assign gsel  = r_x[0] ? r_rd_data[63:32] : r_rd_data[31:0];
    assign dif_l = {quo_l[15], quo_l} - {gsel[15], gsel[15:0]};
    assign dif_r = {quo_r[15], quo_r} - {gsel[31], gsel[31:16]};
    assign abs_l = dif_l[16] ? 17'd0 - dif_l : dif_l;
    assign abs_r = dif_r[16] ? 17'd0 - dif_r : dif_r;
    assign smp_l = (r_mode == MODE_PREDICT && abs_l <= {1'b0, r_thr}) ? gsel[15:0] : quo_l;
    assign smp_r = (r_mode == MODE_PREDICT && abs_r <= {1'b0, r_thr}) ? gsel[31:16] : quo_r;

    assign req_l.start = (r_state == ST_CSTART);
    assign req_l.num   = r_num_l;
    assign req_r.start = (r_state == ST_CSTART);
    assign req_r.num   = r_num_r;

    cdfec_div u_div_l (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_req   (req_l),
        .i_den   (r_tot),
        .o_done  (done_l),
        .o_quo   (quo_l)
    );

    cdfec_div u_div_r (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_req   (req_r),
        .i_den   (r_tot),
        .o_done  (done_r),
        .o_quo   (quo_r)
    );

    assign mem_we    = (r_state == ST_STORE);
    assign mem_waddr = r_base + ADDR_W'(r_x);
    assign mem_raddr = r_base + ADDR_W'(r_x[2:1]);

    always_comb begin
        unique case (r_x[1:0])
            2'd0:    mem_wdata = r_in[63:0];
            2'd1:    mem_wdata = r_in[127:64];
            default: mem_wdata = r_in[191:128];
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (mem_we) begin
            r_mem[mem_waddr] <= mem_wdata;
        end
        r_rd_data <= r_mem[mem_raddr];
    end

    always_comb begin
        emit   = 1'b0;
        e_data = '0;
        e_kind = KIND_SILENCE;
        e_last = 1'b0;
        unique case (r_state)
            ST_FLUSH: begin
                emit   = out_free;
                e_last = last_frame && !r_has_fin;
            end
            ST_CEMIT: begin
                emit   = out_free;
                e_data = r_frame;
                e_kind = KIND_CONCEALED;
                e_last = last_frame && !r_has_fin;
            end
            ST_FINAL: begin
                emit   = out_free;
                e_data = (r_fin_kind == KIND_SILENCE) ? '0 : r_in;
                e_kind = r_fin_kind;
                e_last = 1'b1;
            end
            default: begin
                emit = 1'b0;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_o_valid <= 1'b0;
        end else if (emit) begin
            r_o_valid <= 1'b1;
            r_o_data  <= e_data;
            r_o_kind  <= e_kind;
            r_o_last  <= e_last;
        end else if (!i_out_stall) begin
            r_o_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_mode <= MODE_SILENCE;
            r_pad  <= 1'b0;
            r_thr  <= THR_RESET;
        end else if (i_cfg_we) begin
            case (i_cfg_idx)
                CFG_MODE: r_mode <= i_cfg_data[1:0];
                CFG_PAD:  r_pad  <= i_cfg_data[0];
                CFG_THR:  r_thr  <= i_cfg_data;
                default:  r_pad  <= r_pad;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state   <= ST_IDLE;
            r_seen    <= 1'b0;
            r_prior_l <= '0;
            r_prior_r <= '0;
            r_run_len <= '0;
        end else begin
            unique case (r_state)
                ST_IDLE: begin
                    if (acc) begin
                        r_in       <= {i_in_bytes_high, i_in_bytes_mid, i_in_bytes_low};
                        r_good     <= good;
                        r_seen     <= r_seen || good;
                        r_fin_kind <= fin_kind;
                        r_has_fin  <= has_fin;
                        r_do_store <= do_store;
                        r_cnt      <= '0;
                        r_x        <= '0;
                        r_base     <= do_flush ? '0 : base3;
                        r_tot      <= tot6;
                        r_dl       <= sx16(end_l) - sx16(r_prior_l);
                        r_dr       <= sx16(end_r) - sx16(r_prior_r);
                        if (r_mode[1] && !i_frame_corrupt && r_run_len == '0) begin
                            r_prior_l <= good ? i_in_bytes_high[47:32] : 16'd0;
                            r_prior_r <= good ? i_in_bytes_high[63:48] : 16'd0;
                        end
                        if (do_flush) begin
                            r_state <= ST_FLUSH;
                        end else if (do_store) begin
                            r_state <= ST_STORE;
                        end else if (do_conc) begin
                            r_state <= ST_CINIT;
                        end else if (has_fin) begin
                            r_state <= ST_FINAL;
                        end
                    end
                end
                ST_FLUSH: begin
                    if (emit) begin
                        r_cnt <= r_cnt + RUN_W'(1);
                        if (last_frame) begin
                            r_run_len <= '0;
                            r_prior_l <= '0;
                            r_prior_r <= '0;
                            if (r_do_store) begin
                                r_state <= ST_STORE;
                            end else if (r_has_fin) begin
                                r_state <= ST_FINAL;
                            end else begin
                                r_state <= ST_IDLE;
                            end
                        end
                    end
                end
                ST_STORE: begin
                    r_x <= r_x + 3'd1;
                    if (r_x == 3'd2) begin
                        r_run_len <= r_run_len + RUN_W'(1);
                        r_state   <= ST_IDLE;
                    end
                end
                ST_CINIT: begin
                    r_num_l   <= sx16(r_prior_l) * $signed(NUM_W'(r_tot)) + r_dl;
                    r_num_r   <= sx16(r_prior_r) * $signed(NUM_W'(r_tot)) + r_dr;
                    r_prior_l <= r_good ? r_in[175:160] : 16'd0;
                    r_prior_r <= r_good ? r_in[191:176] : 16'd0;
                    r_base    <= '0;
                    r_cnt     <= '0;
                    r_x       <= '0;
                    r_state   <= ST_CSTART;
                end
                ST_CSTART: begin
                    r_state <= ST_CWAIT;
                end
                ST_CWAIT: begin
                    if (done_l && done_r) begin
                        r_frame[{r_x, 5'b0} +: 32] <= {smp_r, smp_l};
                        r_num_l <= r_num_l + r_dl;
                        r_num_r <= r_num_r + r_dr;
                        if (r_x == 3'(SAMPLES_PER_FRAME - 1)) begin
                            r_state <= ST_CEMIT;
                        end else begin
                            r_x     <= r_x + 3'd1;
                            r_state <= ST_CSTART;
                        end
                    end
                end
                ST_CEMIT: begin
                    if (emit) begin
                        r_x    <= '0;
                        r_base <= r_base + ADDR_W'(3);
                        r_cnt  <= r_cnt + RUN_W'(1);
                        if (last_frame) begin
                            r_run_len <= '0;
                            r_state   <= r_has_fin ? ST_FINAL : ST_IDLE;
                        end else begin
                            r_state <= ST_CSTART;
                        end
                    end
                end
                ST_FINAL: begin
                    if (emit) begin
                        r_state <= ST_IDLE;
                    end
                end
                default: begin
                    r_state <= ST_IDLE;
                end
            endcase
        end
    end

    assign o_in_stall       = (r_state != ST_IDLE);
    assign o_out_valid      = r_o_valid;
    assign o_out_bytes_low  = r_o_data[63:0];
    assign o_out_bytes_mid  = r_o_data[127:64];
    assign o_out_bytes_high = r_o_data[191:128];
    assign o_frame_kind     = r_o_kind;
    assign o_last_of_run    = r_o_last;

    a_run_len_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_run_len <= RUN_W'(MAX_RUN_FRAMES))
        else $error("run length beyond limit");

    a_div_lockstep: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        done_l == done_r)
        else $error("channel dividers out of step");

    a_store_conceal: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == ST_STORE) |-> r_mode[1])
        else $error("frame stored outside conceal mode");

    a_no_overwrite: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && i_out_stall) |-> !emit)
        else $error("pending result overwritten");

endmodule
`default_nettype wire

/* tb/tb_top.sv */
`default_nettype none
module tb_top;
    timeunit 1ns;
    timeprecision 1ps;
    import cdfec_pkg::*;

    typedef struct {
        logic [63:0] lo;
        logic [63:0] mid;
        logic [63:0] hi;
        logic        corrupt;
        logic        missing;
    } t_audio_req;

    typedef struct {
        logic [63:0] lo;
        logic [63:0] mid;
        logic [63:0] hi;
        logic [1:0]  kind;
        logic        last;
    } t_audio_out;

    logic        i_clk;
    logic        i_rst_n;
    logic        i_cfg_we;
    logic [1:0]  i_cfg_idx;
    logic [15:0] i_cfg_data;
    logic        i_in_valid;
    logic        o_in_stall;
    logic [63:0] i_in_bytes_low;
    logic [63:0] i_in_bytes_mid;
    logic [63:0] i_in_bytes_high;
    logic        i_frame_corrupt;
    logic        i_frame_missing;
    logic        o_out_valid;
    logic        i_out_stall;
    logic [63:0] o_out_bytes_low;
    logic [63:0] o_out_bytes_mid;
    logic [63:0] o_out_bytes_high;
    logic [1:0]  o_frame_kind;
    logic        o_last_of_run;

    cd_audio_frame_error_concealer dut (.*);

    t_audio_req pending_reqs[$];
    t_audio_out expected_frames[$];
    int         send_idle_pct;
    int         recv_stall_pct;
    int         errors;
    logic       in_taken;

    logic [1:0]  mdl_mode;
    logic        mdl_pad;
    logic [15:0] mdl_thr;
    logic        mdl_seen_good;
    logic [15:0] mdl_prior_l;
    logic [15:0] mdl_prior_r;
    logic [63:0] mdl_run[3*MAX_RUN_FRAMES];
    int          mdl_run_len;

    initial begin
        i_clk = 1'b0;
        forever #5 i_clk = ~i_clk;
    end

    function automatic logic [31:0] get_pair(logic [191:0] f, int x);
        return f[x*32 +: 32];
    endfunction

    function automatic int signed lerp_sample(int signed s, int signed e, int signed i,
                                              int signed tot);
        return (s * tot + (e - s) * i) / tot;
    endfunction

    task automatic push_frame(logic [191:0] f, logic [1:0] kind);
        t_audio_out o;
        o.lo = f[63:0];
        o.mid = f[127:64];
        o.hi = f[191:128];
        o.kind = kind;
        o.last = 1'b0;
        expected_frames.push_back(o);
    endtask

    task automatic flush_run_silence();
        for (int k = 0; k < mdl_run_len; k++) push_frame('0, KIND_SILENCE);
        mdl_run_len = 0;
        mdl_prior_l = '0;
        mdl_prior_r = '0;
    endtask

    task automatic conceal_held_run(int signed el, int signed er);
        int signed tot;
        int signed sl;
        int signed sr;
        int signed l;
        int signed r;
        int signed gl;
        int signed gr;
        int signed d;
        logic [191:0] held;
        logic [191:0] f;
        tot = mdl_run_len * SAMPLES_PER_FRAME;
        sl = $signed(mdl_prior_l);
        sr = $signed(mdl_prior_r);
        for (int k = 0; k < mdl_run_len; k++) begin
            held = {mdl_run[3*k+2], mdl_run[3*k+1], mdl_run[3*k]};
            f = '0;
            for (int x = 0; x < SAMPLES_PER_FRAME; x++) begin
                l = lerp_sample(sl, el, k * SAMPLES_PER_FRAME + x + 1, tot);
                r = lerp_sample(sr, er, k * SAMPLES_PER_FRAME + x + 1, tot);
                if (mdl_mode == MODE_PREDICT) begin
                    gl = $signed(held[x*32 +: 16]);
                    gr = $signed(held[x*32+16 +: 16]);
                    d = (l > gl) ? l - gl : gl - l;
                    if (d <= int'(mdl_thr)) l = gl;
                    d = (r > gr) ? r - gr : gr - r;
                    if (d <= int'(mdl_thr)) r = gr;
                end
                f[x*32 +: 16] = l[15:0];
                f[x*32+16 +: 16] = r[15:0];
            end
            push_frame(f, KIND_CONCEALED);
        end
        mdl_run_len = 0;
    endtask

    task automatic predict_frames(t_audio_req q);
        logic [191:0] f;
        logic         good;
        int           n0;
        int signed    el;
        int signed    er;
        f = {q.hi, q.mid, q.lo};
        good = !q.corrupt && !q.missing;
        n0 = expected_frames.size();
        el = 0;
        er = 0;
        if (mdl_mode == MODE_SILENCE || mdl_mode == MODE_PASS) begin
            if (mdl_run_len > 0) flush_run_silence();
            if (good) mdl_seen_good = 1'b1;
            if (mdl_pad || mdl_seen_good) begin
                if (good) push_frame(f, KIND_GOOD);
                else if (q.missing || mdl_mode == MODE_SILENCE) push_frame('0, KIND_SILENCE);
                else push_frame(f, KIND_PASSED);
            end
        end else if (q.corrupt) begin
            if (mdl_run_len >= MAX_RUN_FRAMES) flush_run_silence();
            mdl_run[3*mdl_run_len] = q.lo;
            mdl_run[3*mdl_run_len+1] = q.mid;
            mdl_run[3*mdl_run_len+2] = q.hi;
            mdl_run_len++;
        end else begin
            if (good) begin
                el = $signed(f[15:0]);
                er = $signed(f[31:16]);
            end
            if (mdl_run_len > 0) conceal_held_run(el, er);
            if (good) begin
                mdl_seen_good = 1'b1;
                push_frame(f, KIND_GOOD);
                mdl_prior_l = f[5*32 +: 16];
                mdl_prior_r = f[5*32+16 +: 16];
            end else begin
                if (mdl_pad || mdl_seen_good) push_frame('0, KIND_SILENCE);
                mdl_prior_l = '0;
                mdl_prior_r = '0;
            end
        end
        if (expected_frames.size() > n0) expected_frames[$].last = 1'b1;
    endtask

    always @(negedge i_clk) begin
        if (!i_rst_n) begin
            i_in_valid <= 1'b0;
            i_out_stall <= 1'b0;
        end else begin
            i_out_stall <= ($urandom_range(99) < recv_stall_pct);
            if (!i_in_valid || in_taken) begin
                if (pending_reqs.size() > 0 && $urandom_range(99) >= send_idle_pct) begin
                    i_in_valid <= 1'b1;
                    i_in_bytes_low <= pending_reqs[0].lo;
                    i_in_bytes_mid <= pending_reqs[0].mid;
                    i_in_bytes_high <= pending_reqs[0].hi;
                    i_frame_corrupt <= pending_reqs[0].corrupt;
                    i_frame_missing <= pending_reqs[0].missing;
                    void'(pending_reqs.pop_front());
                end else begin
                    i_in_valid <= 1'b0;
                end
            end
        end
    end

    always @(posedge i_clk) begin
        t_audio_req q;
        t_audio_out e;
        in_taken <= i_rst_n && i_in_valid && !o_in_stall;
        if (i_rst_n) begin
            if (i_in_valid && !o_in_stall) begin
                q.lo = i_in_bytes_low;
                q.mid = i_in_bytes_mid;
                q.hi = i_in_bytes_high;
                q.corrupt = i_frame_corrupt;
                q.missing = i_frame_missing;
                predict_frames(q);
            end
            if (o_out_valid && !i_out_stall) begin
                if (expected_frames.size() == 0) begin
                    $display("%0t: unexpected frame %h %h %h kind %0d", $realtime,
                             o_out_bytes_low, o_out_bytes_mid, o_out_bytes_high,
                             o_frame_kind);
                    errors++;
                end else begin
                    e = expected_frames.pop_front();
                    if (e.lo !== o_out_bytes_low || e.mid !== o_out_bytes_mid ||
                        e.hi !== o_out_bytes_high || e.kind !== o_frame_kind ||
                        e.last !== o_last_of_run) begin
                        $display("%0t: expected %h %h %h kind %0d last %0d", $realtime,
                                 e.lo, e.mid, e.hi, e.kind, e.last);
                        $display("%0t: actual   %h %h %h kind %0d last %0d", $realtime,
                                 o_out_bytes_low, o_out_bytes_mid, o_out_bytes_high,
                                 o_frame_kind, o_last_of_run);
                        errors++;
                    end
                end
            end
        end
    end

    function automatic logic [63:0] rand64();
        return {$urandom, $urandom};
    endfunction

    function automatic logic [15:0] rand_sample();
        case ($urandom_range(5))
            0: return 16'h7fff;
            1: return 16'h8000;
            2: return 16'($urandom_range(63));
            3: return -16'($urandom_range(63));
            default: return 16'($urandom);
        endcase
    endfunction

    function automatic logic [63:0] rand_word();
        return {rand_sample(), rand_sample(), rand_sample(), rand_sample()};
    endfunction

    task automatic add_req(logic [63:0] lo, logic [63:0] mid, logic [63:0] hi,
                           logic c, logic m);
        t_audio_req q;
        q.lo = lo;
        q.mid = mid;
        q.hi = hi;
        q.corrupt = c;
        q.missing = m;
        pending_reqs.push_back(q);
    endtask

    task automatic add_random(logic c, logic m);
        if ($urandom_range(3) == 0) add_req(rand64(), rand64(), rand64(), c, m);
        else add_req(rand_word(), rand_word(), rand_word(), c, m);
    endtask

    task automatic write_reg(logic [1:0] idx, logic [15:0] val);
        @(negedge i_clk);
        i_cfg_we <= 1'b1;
        i_cfg_idx <= idx;
        i_cfg_data <= val;
        @(negedge i_clk);
        i_cfg_we <= 1'b0;
        case (idx)
            CFG_MODE: mdl_mode = val[1:0];
            CFG_PAD:  mdl_pad = val[0];
            default:  mdl_thr = val;
        endcase
    endtask

    task automatic drain();
        wait (pending_reqs.size() == 0);
        @(posedge i_clk);
        while (i_in_valid || expected_frames.size() != 0) @(posedge i_clk);
        repeat (6 * MAX_RUN_FRAMES * (NUM_W + 2) + 50) @(posedge i_clk);
    endtask

    task automatic run_random(int count);
        int runlen;
        int sent;
        sent = 0;
        while (sent < count) begin
            case ($urandom_range(9))
                0, 1, 2, 3: begin
                    runlen = ($urandom_range(7) == 0) ? $urandom_range(MAX_RUN_FRAMES + 4)
                                                      : $urandom_range(1, 4);
                    for (int k = 0; k < runlen; k++) add_random(1'b1, $urandom_range(1));
                    add_random(1'b0, ($urandom_range(4) == 0));
                    sent += runlen + 1;
                end
                default: begin
                    add_random($urandom_range(1), $urandom_range(1));
                    sent++;
                end
            endcase
        end
    endtask

    initial begin
        errors = 0;
        send_idle_pct = 0;
        recv_stall_pct = 0;
        i_rst_n = 1'b0;
        i_cfg_we = 1'b0;
        i_cfg_idx = CFG_MODE;
        i_cfg_data = '0;
        i_in_valid = 1'b0;
        i_out_stall = 1'b0;
        i_in_bytes_low = '0;
        i_in_bytes_mid = '0;
        i_in_bytes_high = '0;
        i_frame_corrupt = 1'b0;
        i_frame_missing = 1'b0;
        mdl_mode = MODE_SILENCE;
        mdl_pad = 1'b0;
        mdl_thr = THR_RESET;
        mdl_seen_good = 1'b0;
        mdl_prior_l = '0;
        mdl_prior_r = '0;
        mdl_run_len = 0;
        repeat (10) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;

        add_req('1, '1, '1, 1'b1, 1'b0);
        add_req('0, '0, '0, 1'b0, 1'b1);
        add_req(64'h8000_7fff_8000_7fff, '1, '0, 1'b0, 1'b0);
        add_req('1, '1, '1, 1'b1, 1'b0);
        add_req('0, '0, '0, 1'b1, 1'b1);
        drain();
        write_reg(CFG_MODE, MODE_PASS);
        add_req('1, 64'h1234, '0, 1'b1, 1'b0);
        add_req('0, '1, '0, 1'b0, 1'b1);
        drain();
        write_reg(CFG_MODE, MODE_LINEAR);
        write_reg(CFG_PAD, 16'd1);
        add_req('1, '1, '1, 1'b1, 1'b0);
        add_req('1, '1, '1, 1'b1, 1'b0);
        add_req(64'h7fff_7fff_8000_8000, '1, 64'h8000_7fff_0000_0000, 1'b0, 1'b0);
        add_req('1, '1, '1, 1'b1, 1'b0);
        add_req('0, '0, '0, 1'b0, 1'b1);
        for (int k = 0; k <= MAX_RUN_FRAMES; k++) add_random(1'b1, 1'b0);
        add_req(64'h8000_8000_8000_8000, '0, '0, 1'b0, 1'b0);
        drain();
        write_reg(CFG_MODE, MODE_PREDICT);
        write_reg(CFG_THR, 16'hffff);
        add_req('1, '1, '1, 1'b1, 1'b0);
        add_req(64'h7fff_7fff, '0, '0, 1'b0, 1'b0);
        drain();
        write_reg(CFG_THR, 16'd0);
        add_req(64'h0001_0001, '0, '0, 1'b1, 1'b0);
        add_req('0, '0, '0, 1'b0, 1'b0);
        add_req('1, '1, '1, 1'b1, 1'b0);
        drain();

        for (int ph = 0; ph < 8; ph++) begin
            case (ph % 4)
                0: begin send_idle_pct = 0;  recv_stall_pct = 0;  end
                1: begin send_idle_pct = 62; recv_stall_pct = 0;  end
                2: begin send_idle_pct = 0;  recv_stall_pct = 62; end
                default: begin send_idle_pct = 9; recv_stall_pct = 9; end
            endcase
            write_reg(CFG_MODE, 2'(ph));
            write_reg(CFG_PAD, 16'($urandom_range(1)));
            write_reg(CFG_THR, (ph == 3) ? 16'hffff : 16'($urandom_range(2048)));
            run_random(54);
            drain();
        end

        if (errors == 0) $display("PASS cd_audio_frame_error_concealer");
        else $display("FAIL cd_audio_frame_error_concealer");
        $finish;
    end

    initial begin
        #200ms;
        $display("FAIL cd_audio_frame_error_concealer");
        $finish;
    end
endmodule
`default_nettype wire
